### sv/port_bind_acl_check_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef PORT_BIND_ACL_CHECK_ASSERT_SVH
`define PORT_BIND_ACL_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port bind check assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PBAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port bind check assertion failed");

`endif

### sv/pbac_pkg.sv
package pbac_pkg;

  localparam int RULE_IDX_W = 6;
  localparam int ID_W       = 32;
  localparam int PORT_W     = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PORT_W-1:0] PORT_LIMIT_RST  = 16'd1023;
  localparam logic              PRIV_EXEMPT_RST = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_CHECK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    VERDICT_ALLOW   = 2'd0,
    VERDICT_DENY    = 2'd1,
    VERDICT_BADADDR = 2'd2
  } verdict_t;

  localparam logic [KIND_W-1:0] KIND_TCP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UDP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXEMPT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              is_group;
    logic [ID_W-1:0]   id;
    logic              udp;
    logic [PORT_W-1:0] port;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    logic accept_wr;
    logic accept_add;
    logic accept_chk;
    logic mem_clr;
    logic mem_rd;
    logic eval;
    logic finish;
  } cmd_t;

endpackage

### sv/port_bind_acl_check.sv
// Port bind access check.
// Items enter through start/busy: a transfer happens at a clock edge where
// start is high and busy is low, with in_action selecting the operation.
// A rule write stores one table entry and an add appends one pending group;
// both complete in the transfer cycle, so busy stays low and another item
// may follow in the very next cycle. Neither produces a result.
// A check walks every rule slot, one slot per cycle through the registered
// read port of the rule memory, comparing all pending groups in parallel.
// Busy stays high through the walk and the ST_WAIT and ST_DONE states, and
// the verdict appears on out_verdict with out_valid high for one cycle right
// after busy falls. The walk through the single memory read port sets the
// length of the busy period. The check then empties the pending group list.
// The receiver cannot stall, so results never wait.
// After reset, the block sweeps every slot of the rule memory to invalidate
// it; busy is high during the sweep. Configuration
// writes through cfg_we/cfg_index/cfg_wdata are accepted at any time and
// take effect at once; they must only happen while the block is idle.
module port_bind_acl_check
  import pbac_pkg::*;
#(
  parameter int NUM_RULES  = 64,
  parameter int MAX_GROUPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic [RULE_IDX_W-1:0] in_rule_index,
  input  logic                  in_rule_valid,
  input  logic                  in_rule_is_group,
  input  logic [ID_W-1:0]       in_ident,
  input  logic [ID_W-1:0]       in_primary_group,
  input  logic [KIND_W-1:0]     in_proto_kind,
  input  logic [PORT_W-1:0]     in_port_number,
  input  logic                  in_privileged,
  input  logic                  in_domain_is_inet,
  input  logic                  in_addr_is_inet,
  output logic                  out_valid,
  output logic [1:0]            out_verdict,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RULE_AW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

  // Commands from the sequencer to the datapath, plus the slot address
  // used both by the reset sweep and by the rule walk.
  cmd_t               cmd;
  logic [RULE_AW-1:0] addr;

  pbac_ctrl #(
    .NUM_RULES (NUM_RULES),
    .RULE_AW   (RULE_AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .cmd       (cmd),
    .addr      (addr)
  );

  pbac_dp #(
    .NUM_RULES  (NUM_RULES),
    .MAX_GROUPS (MAX_GROUPS),
    .RULE_AW    (RULE_AW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .addr              (addr),
    .in_rule_index     (in_rule_index),
    .in_rule_valid     (in_rule_valid),
    .in_rule_is_group  (in_rule_is_group),
    .in_ident          (in_ident),
    .in_primary_group  (in_primary_group),
    .in_proto_kind     (in_proto_kind),
    .in_port_number    (in_port_number),
    .in_privileged     (in_privileged),
    .in_domain_is_inet (in_domain_is_inet),
    .in_addr_is_inet   (in_addr_is_inet),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_verdict       (out_verdict)
  );

endmodule

### sv/pbac_ram.sv
module pbac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/pbac_ctrl.sv
module pbac_ctrl
  import pbac_pkg::*;
#(
  parameter int NUM_RULES = 64,
  parameter int RULE_AW   = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_action,
  output logic               busy,
  output cmd_t               cmd,
  output logic [RULE_AW-1:0] addr
);

  localparam logic [RULE_AW-1:0] LAST = RULE_AW'(NUM_RULES - 1);

  state_t             state_r, state_nxt;
  logic [RULE_AW-1:0] cnt_r, cnt_nxt;
  logic               eval_r;
  logic               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      eval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      eval_r  <= cmd.mem_rd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.eval  = eval_r;
    accept    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.mem_clr = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        accept = start;
        if (accept) begin
          case (in_action)
            ACT_WRITE: cmd.accept_wr  = 1'b1;
            ACT_ADD:   cmd.accept_add = 1'b1;
            ACT_CHECK: begin
              cmd.accept_chk = 1'b1;
              cnt_nxt        = '0;
              state_nxt      = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.mem_rd = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_WAIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign addr = cnt_r;

endmodule

### sv/pbac_dp.sv
module pbac_dp
  import pbac_pkg::*;
#(
  parameter int NUM_RULES  = 64,
  parameter int MAX_GROUPS = 16,
  parameter int RULE_AW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [RULE_AW-1:0]    addr,
  input  logic [RULE_IDX_W-1:0] in_rule_index,
  input  logic                  in_rule_valid,
  input  logic                  in_rule_is_group,
  input  logic [ID_W-1:0]       in_ident,
  input  logic [ID_W-1:0]       in_primary_group,
  input  logic [KIND_W-1:0]     in_proto_kind,
  input  logic [PORT_W-1:0]     in_port_number,
  input  logic                  in_privileged,
  input  logic                  in_domain_is_inet,
  input  logic                  in_addr_is_inet,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [1:0]            out_verdict
);

  localparam int GC_W = $clog2(MAX_GROUPS + 1);
  localparam int GI_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // Configuration registers.
  logic [PORT_W-1:0] port_limit_r;
  logic              exempt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_limit_r <= PORT_LIMIT_RST;
      exempt_r     <= PRIV_EXEMPT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PORT_LIMIT:  port_limit_r <= cfg_wdata[PORT_W-1:0];
        CFG_PRIV_EXEMPT: exempt_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Rule table memory; the clear sweep writes all-zero entries.
  logic               idx_ok;
  logic               mem_we;
  logic [RULE_AW-1:0] mem_waddr;
  rule_t              mem_wdata;
  rule_t              rule;
  logic [RULE_W-1:0]  mem_rdata;

  assign idx_ok = (32'(in_rule_index) < 32'(NUM_RULES));
  assign mem_we = cmd.mem_clr | (cmd.accept_wr & idx_ok);
  assign mem_waddr = cmd.mem_clr ? addr : RULE_AW'(in_rule_index);

  always_comb begin
    mem_wdata          = '0;
    if (!cmd.mem_clr) begin
      mem_wdata.valid    = in_rule_valid;
      mem_wdata.is_group = in_rule_is_group;
      mem_wdata.id       = in_ident;
      mem_wdata.udp      = in_proto_kind[0];
      mem_wdata.port     = in_port_number;
    end
  end

  pbac_ram #(
    .WIDTH (RULE_W),
    .DEPTH (NUM_RULES),
    .AW    (RULE_AW)
  ) u_rules (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.mem_rd),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  assign rule = rule_t'(mem_rdata);

  // Pending supplementary groups.
  logic [ID_W-1:0] grp_r [MAX_GROUPS];
  logic [GC_W-1:0] grp_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= '0;
    end else if (cmd.finish) begin
      grp_cnt_r <= '0;
    end else if (cmd.accept_add && (grp_cnt_r < GC_W'(MAX_GROUPS))) begin
      grp_cnt_r <= grp_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_add && (grp_cnt_r < GC_W'(MAX_GROUPS))) begin
      grp_r[grp_cnt_r[GI_W-1:0]] <= in_ident;
    end
  end

  // Latched request of the check in progress.
  logic [ID_W-1:0]   uid_r, pgid_r;
  logic [PORT_W-1:0] port_r;
  logic              udp_r, dom_r, other_r, addr_r, above_r, priv_r;
  logic              hit_r;

  always_ff @(posedge clk) begin
    if (cmd.accept_chk) begin
      uid_r   <= in_ident;
      pgid_r  <= in_primary_group;
      port_r  <= in_port_number;
      udp_r   <= (in_proto_kind == KIND_UDP);
      other_r <= (in_proto_kind > KIND_UDP);
      dom_r   <= in_domain_is_inet;
      addr_r  <= in_addr_is_inet;
      above_r <= (in_port_number > port_limit_r);
      priv_r  <= in_privileged;
    end
  end

  // Match of the entry read back this cycle.
  logic grp_hit;
  logic match;

  always_comb begin
    grp_hit = 1'b0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      if ((GC_W'(i) < grp_cnt_r) && (grp_r[i] == rule.id)) begin
        grp_hit = 1'b1;
      end
    end
  end

  assign match = rule.valid && (rule.udp == udp_r) && (rule.port == port_r) &&
                 (rule.is_group ? ((rule.id == pgid_r) || grp_hit)
                                : (rule.id == uid_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.accept_chk) begin
      hit_r <= 1'b0;
    end else if (cmd.eval && match) begin
      hit_r <= 1'b1;
    end
  end

  // Final decision, in the order the checks are specified.
  verdict_t verdict;
  verdict_t verdict_r;
  logic     out_valid_r;

  always_comb begin
    priority if (!dom_r)            verdict = VERDICT_ALLOW;
    else if (other_r)               verdict = VERDICT_ALLOW;
    else if (!addr_r)               verdict = VERDICT_BADADDR;
    else if (above_r)               verdict = VERDICT_ALLOW;
    else if (hit_r)                 verdict = VERDICT_ALLOW;
    else if (exempt_r && priv_r)    verdict = VERDICT_ALLOW;
    else                            verdict = VERDICT_DENY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

### sv/pbac_checker.sv
`include "port_bind_acl_check_assert.svh"

module pbac_checker
  import pbac_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_action,
  input logic       out_valid
);

  logic xfer;
  assign xfer = start && !busy;

  // A check occupies the block for a full rule walk.
  `PBAC_ASSERT_NEXT(a_check_busy, xfer && (in_action == ACT_CHECK), busy)

  // Writes and adds finish in their transfer cycle.
  `PBAC_ASSERT_NEXT(a_quick_free, xfer && (in_action == ACT_WRITE || in_action == ACT_ADD), !busy)

  // A result follows the end of a busy period and is never repeated.
  `PBAC_ASSERT_SAME(a_res_after_busy, out_valid, $past(busy) && !busy)
  `PBAC_ASSERT_NEXT(a_res_single, out_valid, !out_valid)

endmodule

bind port_bind_acl_check pbac_checker u_pbac_checker (.*);

### verif/port_bind_acl_check_tb.sv
// A request as the driver presents it. Every field is carried on every
// transfer, even when the operation ignores it.
typedef struct {
  logic [1:0]                      action;
  logic [pbac_pkg::RULE_IDX_W-1:0] rule_index;
  logic                            rule_valid;
  logic                            rule_is_group;
  logic [pbac_pkg::ID_W-1:0]       ident;
  logic [pbac_pkg::ID_W-1:0]       primary_group;
  logic [pbac_pkg::KIND_W-1:0]     proto_kind;
  logic [pbac_pkg::PORT_W-1:0]     port_number;
  logic                            privileged;
  logic                            domain_is_inet;
  logic                            addr_is_inet;
} bind_req_t;

// Keeps a private copy of the rule table, the pending group list and the
// two registers, and queues the verdict that each accepted check must give.
class bind_verdict_scoreboard;
  localparam int RULE_SLOTS  = 64;
  localparam int GROUP_DEPTH = 16;

  pbac_pkg::rule_t              rules[RULE_SLOTS];
  logic [pbac_pkg::ID_W-1:0]    groups[GROUP_DEPTH];
  int unsigned                  ngroups;
  logic [pbac_pkg::PORT_W-1:0]  port_limit;
  logic                         exempt;
  pbac_pkg::verdict_t           pending_verdicts[$];
  int unsigned                  errors;

  function new();
    foreach (rules[i]) rules[i] = '0;
    foreach (groups[i]) groups[i] = '0;
    ngroups    = 0;
    port_limit = pbac_pkg::PORT_LIMIT_RST;
    exempt     = pbac_pkg::PRIV_EXEMPT_RST;
    errors     = 0;
  endfunction

  function void write_register(logic [pbac_pkg::CFG_IDX_W-1:0] idx,
                               logic [pbac_pkg::CFG_DATA_W-1:0] data);
    if (idx == pbac_pkg::CFG_PORT_LIMIT) begin
      port_limit = data;
    end else if (idx == pbac_pkg::CFG_PRIV_EXEMPT) begin
      exempt = data[0];
    end
  endfunction

  function pbac_pkg::verdict_t decide(bind_req_t r);
    logic want_udp;
    logic hit;
    hit = 1'b0;
    if (!r.domain_is_inet) return pbac_pkg::VERDICT_ALLOW;
    if (r.proto_kind > pbac_pkg::KIND_UDP) return pbac_pkg::VERDICT_ALLOW;
    if (!r.addr_is_inet) return pbac_pkg::VERDICT_BADADDR;
    if (r.port_number > port_limit) return pbac_pkg::VERDICT_ALLOW;
    want_udp = (r.proto_kind == pbac_pkg::KIND_UDP);
    foreach (rules[i]) begin
      if (rules[i].valid && rules[i].udp == want_udp &&
          rules[i].port == r.port_number) begin
        if (!rules[i].is_group) begin
          if (rules[i].id == r.ident) hit = 1'b1;
        end else begin
          if (rules[i].id == r.primary_group) hit = 1'b1;
          for (int g = 0; g < ngroups; g++)
            if (groups[g] == rules[i].id) hit = 1'b1;
        end
      end
    end
    if (hit || (exempt && r.privileged)) return pbac_pkg::VERDICT_ALLOW;
    return pbac_pkg::VERDICT_DENY;
  endfunction

  function void note_transfer(bind_req_t r);
    case (r.action)
      pbac_pkg::ACT_WRITE: begin
        rules[r.rule_index].valid    = r.rule_valid;
        rules[r.rule_index].is_group = r.rule_is_group;
        rules[r.rule_index].id       = r.ident;
        rules[r.rule_index].udp      = r.proto_kind[0];
        rules[r.rule_index].port     = r.port_number;
      end
      pbac_pkg::ACT_ADD: begin
        if (ngroups < GROUP_DEPTH) begin
          groups[ngroups] = r.ident;
          ngroups++;
        end
      end
      pbac_pkg::ACT_CHECK: begin
        pending_verdicts.push_back(decide(r));
        ngroups = 0;
      end
      default: ;
    endcase
  endfunction

  function void check_verdict(logic [1:0] got);
    pbac_pkg::verdict_t want;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: verdict mismatch: expected none, got %0d", $time, got);
      errors++;
      return;
    end
    want = pending_verdicts.pop_front();
    if (got !== want) begin
      $display("%0t: verdict mismatch: expected %0d, got %0d", $time, want, got);
      errors++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_verdicts.size();
  endfunction
endclass

module port_bind_acl_check_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbac_pkg::*;

  // A check keeps the block busy while it walks all rule slots, and its
  // verdict shows up once the walk is over.
  localparam int CHECK_LATENCY = 64 + 3;
  // The slowest correct run is roughly 525 items times the check time plus
  // the longest sender gaps, well below this limit.
  localparam int CYCLE_LIMIT = 600000;
  // The action code that the block has no operation for.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // The socket kind code above "other", which the block treats as other.
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_action = '0;
  logic [RULE_IDX_W-1:0] in_rule_index = '0;
  logic                  in_rule_valid = 1'b0;
  logic                  in_rule_is_group = 1'b0;
  logic [ID_W-1:0]       in_ident = '0;
  logic [ID_W-1:0]       in_primary_group = '0;
  logic [KIND_W-1:0]     in_proto_kind = '0;
  logic [PORT_W-1:0]     in_port_number = '0;
  logic                  in_privileged = 1'b0;
  logic                  in_domain_is_inet = 1'b0;
  logic                  in_addr_is_inet = 1'b0;
  logic                  out_valid;
  logic [1:0]            out_verdict;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bind_verdict_scoreboard sb;
  int unsigned            items_sent = 0;
  int unsigned            cycles = 0;

  port_bind_acl_check dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_rule_index     (in_rule_index),
    .in_rule_valid     (in_rule_valid),
    .in_rule_is_group  (in_rule_is_group),
    .in_ident          (in_ident),
    .in_primary_group  (in_primary_group),
    .in_proto_kind     (in_proto_kind),
    .in_port_number    (in_port_number),
    .in_privileged     (in_privileged),
    .in_domain_is_inet (in_domain_is_inet),
    .in_addr_is_inet   (in_addr_is_inet),
    .out_valid         (out_valid),
    .out_verdict       (out_verdict),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Results cannot be held off, so every strobe is a transfer. Sampling at
  // the rising edge sees the values of the cycle that the edge ends.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_verdict(out_verdict);
  end

  // Watchdog: a hang anywhere in the run ends here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Id and port pools keep rules and checks colliding often enough that
  // rule hits, group hits and misses all happen, with a share of fully
  // random values so that every bit still moves.
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      8, 9:    return $urandom;
      default: return 32'd1000 + $urandom_range(0, 5);
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1023;
      2:       return 16'd1024;
      3:       return 16'hFFFF;
      9:       return PORT_W'($urandom_range(0, 65535));
      default: return PORT_W'(80 + $urandom_range(0, 3));
    endcase
  endfunction

  function automatic bind_req_t random_req();
    bind_req_t r;
    r.action         = 2'($urandom_range(0, 3));
    r.rule_index     = RULE_IDX_W'($urandom);
    r.rule_valid     = 1'($urandom);
    r.rule_is_group  = 1'($urandom);
    r.ident          = $urandom;
    r.primary_group  = $urandom;
    r.proto_kind     = KIND_W'($urandom);
    r.port_number    = PORT_W'($urandom);
    r.privileged     = 1'($urandom);
    r.domain_is_inet = 1'($urandom);
    r.addr_is_inet   = 1'($urandom);
    return r;
  endfunction

  // The builders start from random content so that the fields an operation
  // ignores carry garbage rather than zeros.
  function automatic bind_req_t rule_req(logic [RULE_IDX_W-1:0] idx, logic valid,
                                         logic is_group, logic [ID_W-1:0] id,
                                         logic [KIND_W-1:0] kind,
                                         logic [PORT_W-1:0] port_no);
    bind_req_t r;
    r               = random_req();
    r.action        = ACT_WRITE;
    r.rule_index    = idx;
    r.rule_valid    = valid;
    r.rule_is_group = is_group;
    r.ident         = id;
    r.proto_kind    = kind;
    r.port_number   = port_no;
    return r;
  endfunction

  function automatic bind_req_t group_req(logic [ID_W-1:0] id);
    bind_req_t r;
    r        = random_req();
    r.action = ACT_ADD;
    r.ident  = id;
    return r;
  endfunction

  function automatic bind_req_t check_req(logic [ID_W-1:0] uid, logic [ID_W-1:0] gid,
                                          logic [KIND_W-1:0] kind,
                                          logic [PORT_W-1:0] port_no, logic priv,
                                          logic dom, logic addr);
    bind_req_t r;
    r                = random_req();
    r.action         = ACT_CHECK;
    r.ident          = uid;
    r.primary_group  = gid;
    r.proto_kind     = kind;
    r.port_number    = port_no;
    r.privileged     = priv;
    r.domain_is_inet = dom;
    r.addr_is_inet   = addr;
    return r;
  endfunction

  // Offers one item and holds it until the block takes it. Start is left
  // high so that a following item can go out in the very next cycle; only
  // an idle stretch lowers it, and never in the step that raises it again.
  task automatic issue(input bind_req_t r, input int idle_pct);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      // Mostly short gaps, now and then one long enough to outlast a check.
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_action         <= r.action;
    in_rule_index     <= r.rule_index;
    in_rule_valid     <= r.rule_valid;
    in_rule_is_group  <= r.rule_is_group;
    in_ident          <= r.ident;
    in_primary_group  <= r.primary_group;
    in_proto_kind     <= r.proto_kind;
    in_port_number    <= r.port_number;
    in_privileged     <= r.privileged;
    in_domain_is_inet <= r.domain_is_inet;
    in_addr_is_inet   <= r.addr_is_inet;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_transfer(r);
    if (r.action != ACT_UNUSED) items_sent++;
  endtask

  // Stops offering items until every queued verdict has arrived, then lets
  // a full check time pass so that nothing can still be in flight.
  task automatic wait_quiet();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (CHECK_LATENCY + 1) @(posedge clk);
  endtask

  // Writes both registers back to back; only called while the block is idle.
  task automatic write_settings(input logic [PORT_W-1:0] high, input logic exempt);
    logic [CFG_DATA_W-1:0] exempt_word;
    // Upper bits of the exemption word are junk that the block must ignore.
    exempt_word = {15'($urandom), exempt};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PORT_LIMIT;
    cfg_wdata <= high;
    @(posedge clk);
    sb.write_register(CFG_PORT_LIMIT, high);
    cfg_index <= CFG_PRIV_EXEMPT;
    cfg_wdata <= exempt_word;
    @(posedge clk);
    sb.write_register(CFG_PRIV_EXEMPT, exempt_word);
    cfg_we <= 1'b0;
  endtask

  // Most of the traffic is credential sequences: a few rule writes, a run
  // of group adds (sometimes past the list depth), then a check built from
  // the same pools. The rest is unstructured noise, unused action included.
  task automatic run_phase(input int n_items, input int idle_pct);
    int unsigned stop_at;
    int          n_adds;
    logic [KIND_W-1:0] kind;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        issue(random_req(), idle_pct);
      end else begin
        repeat ($urandom_range(0, 3))
          issue(rule_req(RULE_IDX_W'($urandom), $urandom_range(0, 9) != 0, 1'($urandom),
                         pick_id(), KIND_W'($urandom), pick_port()), idle_pct);
        n_adds = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(12, 20);
        repeat (n_adds) issue(group_req(pick_id()), idle_pct);
        kind = ($urandom_range(0, 9) == 0) ? KIND_W'($urandom_range(2, 3))
                                           : KIND_W'($urandom_range(0, 1));
        issue(check_req(pick_id(), pick_id(), kind, pick_port(), 1'($urandom),
                        $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0),
              idle_pct);
      end
    end
  endtask

  initial begin
    bind_req_t r;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset settings (port limit 1023, exempt on).
    // Empty table: a plain miss is denied, a privileged miss is allowed.
    issue(check_req(5, 5, KIND_TCP, 80, 1'b0, 1'b1, 1'b1), 0);
    issue(check_req(5, 5, KIND_TCP, 80, 1'b1, 1'b1, 1'b1), 0);
    // The domain test wins over a bad address, and so does a non-inet kind.
    issue(check_req(5, 5, KIND_TCP, 80, 1'b0, 1'b0, 1'b0), 0);
    issue(check_req(5, 5, KIND_OTHER, 80, 1'b0, 1'b1, 1'b0), 0);
    issue(check_req(5, 5, KIND_RESERVED, 80, 1'b0, 1'b1, 1'b1), 0);
    issue(check_req(5, 5, KIND_UDP, 80, 1'b0, 1'b1, 1'b0), 0);
    // Ports just above, far above and exactly at the port limit.
    issue(check_req(5, 5, KIND_TCP, 1024, 1'b0, 1'b1, 1'b1), 0);
    issue(check_req(5, 5, KIND_TCP, 16'hFFFF, 1'b0, 1'b1, 1'b1), 0);
    issue(check_req(5, 5, KIND_TCP, 1023, 1'b0, 1'b1, 1'b1), 0);
    // User rule at the top id and the port limit; the udp check must not match it.
    issue(rule_req(0, 1'b1, 1'b0, 32'hFFFF_FFFF, KIND_TCP, 1023), 0);
    issue(check_req(32'hFFFF_FFFF, 0, KIND_TCP, 1023, 1'b0, 1'b1, 1'b1), 0);
    issue(check_req(32'hFFFF_FFFF, 0, KIND_UDP, 1023, 1'b0, 1'b1, 1'b1), 0);
    // Group rule in the last slot; kind 3 on a write stores udp.
    issue(rule_req(63, 1'b1, 1'b1, 0, KIND_RESERVED, 0), 0);
    issue(check_req(7, 0, KIND_UDP, 0, 1'b0, 1'b1, 1'b1), 0);
    // Hit through a pending group, then a miss once the check cleared it.
    issue(group_req(0), 0);
    issue(check_req(7, 9, KIND_UDP, 0, 1'b0, 1'b1, 1'b1), 0);
    issue(check_req(7, 9, KIND_UDP, 0, 1'b0, 1'b1, 1'b1), 0);
    // Kind 2 on a write stores tcp; match on the second pending group.
    issue(rule_req(1, 1'b1, 1'b1, 32'h1234, KIND_OTHER, 80), 0);
    issue(group_req(32'hFFFF_FFFF), 0);
    issue(group_req(32'h1234), 0);
    issue(check_req(0, 0, KIND_TCP, 80, 1'b0, 1'b1, 1'b1), 0);
    // The unused action must leave everything alone.
    r = random_req();
    r.action = ACT_UNUSED;
    issue(r, 0);
    // Invalidating slot 0 turns its hit into a miss, unless privileged.
    issue(rule_req(0, 1'b0, 1'b0, 32'hFFFF_FFFF, KIND_TCP, 1023), 0);
    issue(check_req(32'hFFFF_FFFF, 0, KIND_TCP, 1023, 1'b0, 1'b1, 1'b1), 0);
    issue(check_req(32'hFFFF_FFFF, 0, KIND_TCP, 1023, 1'b1, 1'b1, 1'b1), 0);

    // Random part. Each setting change waits for the block to go quiet,
    // which also covers the sender pausing until all verdicts are back.
    wait_quiet();
    write_settings(16'hFFFF, 1'b0);
    run_phase(85, 31);
    wait_quiet();
    write_settings(16'd0, 1'b1);
    run_phase(85, 31);
    wait_quiet();
    write_settings(PORT_W'($urandom_range(80, 2000)), 1'b0);
    run_phase(170, 67);
    wait_quiet();
    write_settings(16'd1023, 1'b1);
    run_phase(160, 0);
    wait_quiet();

    if (sb.outstanding() != 0) begin
      $display("%0t: verdict mismatch: expected %0d more, got none",
               $time, sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
